// File: rtl/nseu_pkg.sv
`default_nettype none

package nseu_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZSUM,
      ST_LUT,
      ST_GRAD,
      ST_UPD,
      ST_SUM,
      ST_SRC
   } state_type;

   localparam logic [1:0] KIND_DST = 2'd0;
   localparam logic [1:0] KIND_SRC = 2'd1;
   localparam logic [1:0] KIND_SUM = 2'd2;

   localparam logic [1:0] CSR_LEARN_RATE = 2'd0;
   localparam logic [1:0] CSR_REG_WEIGHT = 2'd1;
   localparam logic [1:0] CSR_DIM_USED   = 2'd2;

   localparam longint unsigned LN2_Q32 = 64'd2977044472;

   // unsigned quotient, shift and subtract
   function automatic longint unsigned udiv64(input longint unsigned a,
                                              input longint unsigned b);
      longint unsigned q;
      longint unsigned r;
      q = 64'd0;
      r = 64'd0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], a[i]};
         if (r >= b) begin
            r    = r - b;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // e^-t in Q.31, t in Q.12
   function automatic longint unsigned exp_neg_q31(input longint unsigned t);
      longint unsigned s;
      longint unsigned term;
      longint unsigned y;
      longint sum;
      s    = t << 16;
      term = 64'd1 << 31;
      sum  = longint'(term);
      for (int k = 1; k <= 24; k++) begin
         term = udiv64((term * s) >> 31, 64'(k));
         if ((k & 1) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      y = (sum < 0) ? 64'd0 : longint'(sum);
      for (int i = 0; i < 3; i++) begin
         y = (y * y + (64'd1 << 30)) >> 31;
      end
      return y;
   endfunction

   // logistic at bin center, Q1.14
   function automatic logic [15:0] sig_entry(input int k, input int abits);
      longint bin;
      longint xc;
      longint unsigned t;
      longint unsigned e;
      longint unsigned den;
      longint unsigned f;
      bin = longint'(1) <<< (16 - abits);
      xc  = longint'(k) * bin + (bin >>> 1) - 32768;
      t   = (xc < 0) ? longint'(-xc) : longint'(xc);
      e   = exp_neg_q31(t);
      den = (64'd1 << 31) + e;
      if (xc >= 0) begin
         f = udiv64((64'd1 << 45) + (den >> 1), den);
      end else begin
         f = udiv64(64'd16384 * e + (den >> 1), den);
      end
      if (f > 64'd16384) begin
         f = 64'd16384;
      end
      return f[15:0];
   endfunction

   // 4096 * ln(p/16384 + 2^-24), clamped to <= 0
   function automatic logic [23:0] ln_q12(input longint unsigned p);
      longint unsigned q;
      longint unsigned m;
      longint unsigned a;
      longint unsigned r;
      longint frac;
      longint l2;
      int n;
      q = p * 64'd1024 + 64'd1;
      n = 0;
      for (int i = 0; i < 40; i++) begin
         if ((q >> (n + 1)) != 64'd0) begin
            n = n + 1;
         end
      end
      m    = q << (30 - n);
      frac = 0;
      for (int i = 0; i < 20; i++) begin
         m    = (m * m) >> 30;
         frac = frac <<< 1;
         if (m >= (64'd1 << 31)) begin
            frac = frac | 1;
            m    = m >> 1;
         end
      end
      l2 = longint'(n - 24) * (longint'(1) <<< 20) + frac;
      if (l2 >= 0) begin
         return 24'd0;
      end
      a = longint'(-l2);
      r = (a * LN2_Q32 + (64'd1 << 39)) >> 40;
      return 24'(-longint'(r));
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [24:0] x);
      if (x > 25'sd32767) begin
         return 16'sh7fff;
      end else if (x < -25'sd32768) begin
         return 16'sh8000;
      end
      return x[15:0];
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [24:0] x);
      if (x > 25'sd8388607) begin
         return 24'sh7fffff;
      end else if (x < -25'sd8388608) begin
         return 24'sh800000;
      end
      return x[23:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/nseu_lut_rom.sv
`default_nettype none

module nseu_lut_rom #(
   parameter int ABITS = 10
) (
   input  wire logic             clock,
   input  wire logic [ABITS-1:0] addr,
   output logic      [15:0]      sig_q,
   output logic      [23:0]      llpos_q,
   output logic      [23:0]      llneg_q
);

   localparam int SIZE = 1 << ABITS;

   logic [15:0] sig_tab   [SIZE];
   logic [23:0] llpos_tab [SIZE];
   logic [23:0] llneg_tab [SIZE];

   for (genvar k = 0; k < SIZE; k++) begin : g_entry
      localparam logic [15:0] F  = nseu_pkg::sig_entry(k, ABITS);
      localparam logic [23:0] LP = nseu_pkg::ln_q12(64'(F));
      localparam logic [23:0] LN = nseu_pkg::ln_q12(64'(16'd16384 - F));
      assign sig_tab[k]   = F;
      assign llpos_tab[k] = LP;
      assign llneg_tab[k] = LN;
   end

   always_ff @(posedge clock) begin
      sig_q   <= sig_tab[addr];
      llpos_q <= llpos_tab[addr];
      llneg_q <= llneg_tab[addr];
   end

endmodule

`default_nettype wire

// File: rtl/negative_sampling_embedding_update_core.sv
// channel  direction  handshake              payload
// req      in         start & !busy          elem_index, src/dst elem, label, bias, flags
// rsp      out        rsp_valid (strobe)     kind, out_index, out_value, log_lik, bias_grad
// csr      in         csr_valid & csr_ready  csr_index, csr_wdata
//
// A beat without pair_last is taken while busy stays low.
// A pair_last beat holds busy through the ZSUM, LUT, GRAD, UPD and SUM states,
// plus an SRC pass when sample_last and n > 0 (n = elements in use); the store
// read-modify-write passes set its length.
// Reset is synchronous; stores need no clearing pass.
// rsp cannot stall: each result is shown for one cycle.
`default_nettype none

module negative_sampling_embedding_update_core #(
   parameter int DIM           = 16,
   parameter int LUT_ADDR_BITS = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic        [3:0]  req_elem_index,
   input  wire logic signed [15:0] req_src_elem,
   input  wire logic signed [15:0] req_dst_elem,
   input  wire logic               req_label,
   input  wire logic signed [15:0] req_edge_bias,
   input  wire logic               req_pair_last,
   input  wire logic               req_sample_first,
   input  wire logic               req_sample_last,
   output logic                    rsp_valid,
   output logic             [1:0]  rsp_kind,
   output logic             [3:0]  rsp_out_index,
   output logic signed      [15:0] rsp_out_value,
   output logic signed      [23:0] rsp_log_lik,
   output logic signed      [15:0] rsp_bias_grad,
   output logic                    rsp_run_last,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic        [1:0]  csr_index,
   input  wire logic        [15:0] csr_wdata
);

   localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;
   localparam logic [4:0] NMAX = 5'((DIM < 16) ? DIM : 16);

   nseu_pkg::state_type state_ff, state_in;

   logic [15:0] learn_rate_ff, reg_weight_ff;
   logic [4:0]  dim_used_ff, n_eff;

   logic signed [15:0] src_mem [DIM];
   logic signed [15:0] dst_mem [DIM];
   logic signed [23:0] err_mem [DIM];
   logic [DIM-1:0]     err_vld_ff;

   logic signed [39:0] dot_acc_ff;
   logic               label_ff, first_ff, last_ff;
   logic signed [15:0] bias_ff;
   logic [LUT_ADDR_BITS-1:0] k_ff;
   logic [15:0]        sig_q;
   logic [23:0]        llpos_q, llneg_q;
   logic signed [18:0] gr_ff;
   logic [16:0]        lr_ff;
   logic signed [15:0] g_ff;
   logic signed [23:0] ll_ff;

   logic [4:0]         cnt_ff;
   logic signed [15:0] u_q, v_q;
   logic signed [23:0] e_q;
   logic               e_vq;
   logic               s1_vld_ff, s2_vld_ff;
   logic [3:0]         s1_idx_ff, s2_idx_ff;
   logic signed [34:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [15:0] s2_v_ff;
   logic signed [23:0] s2_e_ff;

   logic               rsp_valid_ff, rsp_run_last_ff;
   logic [1:0]         rsp_kind_ff;
   logic [3:0]         rsp_index_ff;
   logic signed [15:0] rsp_value_ff, rsp_grad_ff;
   logic signed [23:0] rsp_ll_ff;

   logic accept, issue;
   logic [AW-1:0] in_addr, rd_addr;
   logic in_range;
   logic signed [31:0] prod;

   logic signed [40:0] dsum;
   logic signed [29:0] zt;
   logic signed [15:0] z;
   logic [15:0]        zb;

   logic signed [16:0] g_c;
   logic signed [33:0] gp;
   logic [32:0]        lpr;

   logic signed [35:0] de, dv;
   logic signed [24:0] errsum, nvsum, nusum;
   logic signed [23:0] err_new, e_eff;
   logic signed [15:0] nv, nu;

   logic emit;
   logic [1:0] emit_kind;
   logic [3:0] emit_idx;
   logic signed [15:0] emit_val;
   logic emit_last;

   logic src_we, dst_we, err_we;
   logic [AW-1:0] src_wa, dst_wa, err_wa;
   logic signed [15:0] src_wd, dst_wd;

   assign busy      = (state_ff != nseu_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign n_eff     = (dim_used_ff > NMAX) ? NMAX : dim_used_ff;
   assign in_range  = ({1'b0, req_elem_index} < n_eff);
   assign in_addr   = AW'(req_elem_index);
   assign rd_addr   = AW'(cnt_ff);
   assign prod      = req_src_elem * req_dst_elem;
   assign issue     = (cnt_ff < n_eff) &&
                      (state_ff == nseu_pkg::ST_UPD || state_ff == nseu_pkg::ST_SRC);

   assign dsum = {dot_acc_ff[39], dot_acc_ff} + 41'sd2048;
   assign zt   = {dsum[40], dsum[40:12]} + 30'(bias_ff);
   assign z    = nseu_pkg::sat16(25'(zt > 30'sd40000 ? 30'sd40000 :
                                     (zt < -30'sd40000 ? -30'sd40000 : zt)));
   assign zb   = {~z[15], z[14:0]};

   assign g_c = label_ff ? (17'sd16384 - $signed({1'b0, sig_q})) : -$signed({1'b0, sig_q});
   assign gp  = g_c * $signed({1'b0, learn_rate_ff});
   assign lpr = 33'(reg_weight_ff) * 33'(learn_rate_ff) + 33'd32768;

   assign e_eff  = e_vq ? e_q : 24'sd0;
   assign de     = 36'(p1_ff) - 36'(p2_ff) + 36'sd32768;
   assign dv     = 36'(p3_ff) - 36'(p4_ff) + 36'sd32768;
   assign errsum = 25'(s2_e_ff) + 25'($signed(de[35:16]));
   assign err_new = nseu_pkg::sat24(errsum);
   assign nvsum  = 25'(s2_v_ff) + 25'($signed(dv[35:16]));
   assign nv     = nseu_pkg::sat16(nvsum);
   assign nusum  = 25'(u_q) + 25'(e_eff);
   assign nu     = nseu_pkg::sat16(nusum);

   nseu_lut_rom #(
      .ABITS(LUT_ADDR_BITS)
   ) u_lut (
      .clock  (clock),
      .addr   (k_ff),
      .sig_q  (sig_q),
      .llpos_q(llpos_q),
      .llneg_q(llneg_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nseu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      emit      = 1'b0;
      emit_kind = nseu_pkg::KIND_DST;
      emit_idx  = s2_idx_ff;
      emit_val  = nv;
      emit_last = 1'b0;
      src_we    = 1'b0;
      dst_we    = 1'b0;
      err_we    = 1'b0;
      src_wa    = in_addr;
      dst_wa    = in_addr;
      err_wa    = AW'(s2_idx_ff);
      src_wd    = req_src_elem;
      dst_wd    = req_dst_elem;
      case (state_ff)
         nseu_pkg::ST_IDLE: begin
            if (accept) begin
               src_we = in_range;
               dst_we = in_range;
               if (req_pair_last) begin
                  state_in = nseu_pkg::ST_ZSUM;
               end
            end
         end
         nseu_pkg::ST_ZSUM: state_in = nseu_pkg::ST_LUT;
         nseu_pkg::ST_LUT:  state_in = nseu_pkg::ST_GRAD;
         nseu_pkg::ST_GRAD: state_in = nseu_pkg::ST_UPD;
         nseu_pkg::ST_UPD: begin
            if (s2_vld_ff) begin
               emit   = 1'b1;
               dst_we = 1'b1;
               err_we = 1'b1;
               dst_wa = AW'(s2_idx_ff);
               dst_wd = nv;
            end
            if (!issue && !s1_vld_ff && !s2_vld_ff) begin
               state_in = nseu_pkg::ST_SUM;
            end
         end
         nseu_pkg::ST_SUM: begin
            emit      = 1'b1;
            emit_kind = nseu_pkg::KIND_SUM;
            emit_idx  = 4'd0;
            emit_val  = 16'sd0;
            emit_last = !(last_ff && n_eff != 5'd0);
            state_in  = emit_last ? nseu_pkg::ST_IDLE : nseu_pkg::ST_SRC;
         end
         nseu_pkg::ST_SRC: begin
            if (s1_vld_ff) begin
               emit      = 1'b1;
               emit_kind = nseu_pkg::KIND_SRC;
               emit_idx  = s1_idx_ff;
               emit_val  = nu;
               emit_last = ({1'b0, s1_idx_ff} == n_eff - 5'd1);
               src_we    = 1'b1;
               src_wa    = AW'(s1_idx_ff);
               src_wd    = nu;
            end
            if (!issue && !s1_vld_ff) begin
               state_in = nseu_pkg::ST_IDLE;
            end
         end
         default: state_in = nseu_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff <= 16'd1638;
         reg_weight_ff <= 16'd0;
         dim_used_ff   <= 5'd16;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            nseu_pkg::CSR_LEARN_RATE: learn_rate_ff <= csr_wdata;
            nseu_pkg::CSR_REG_WEIGHT: reg_weight_ff <= csr_wdata;
            nseu_pkg::CSR_DIM_USED:   dim_used_ff   <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[src_wa] <= src_wd;
      end
      if (dst_we) begin
         dst_mem[dst_wa] <= dst_wd;
      end
      if (err_we) begin
         err_mem[err_wa] <= err_new;
      end
      u_q  <= src_mem[rd_addr];
      v_q  <= dst_mem[rd_addr];
      e_q  <= err_mem[rd_addr];
      e_vq <= err_vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_vld_ff <= '0;
         dot_acc_ff <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         if (state_ff == nseu_pkg::ST_GRAD && first_ff) begin
            err_vld_ff <= '0;
         end else if (err_we) begin
            err_vld_ff[err_wa] <= 1'b1;
         end
         if (accept && in_range) begin
            dot_acc_ff <= dot_acc_ff + 40'(prod);
         end else if (state_ff == nseu_pkg::ST_ZSUM) begin
            dot_acc_ff <= '0;
         end
         if (state_ff == nseu_pkg::ST_GRAD || state_ff == nseu_pkg::ST_SUM) begin
            cnt_ff <= '0;
         end else if (issue) begin
            cnt_ff <= cnt_ff + 5'd1;
         end
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff && (state_ff == nseu_pkg::ST_UPD);
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_pair_last) begin
         label_ff <= req_label;
         bias_ff  <= req_edge_bias;
         first_ff <= req_sample_first;
         last_ff  <= req_sample_last;
      end
      if (state_ff == nseu_pkg::ST_ZSUM) begin
         k_ff <= zb[15 -: LUT_ADDR_BITS];
      end
      if (state_ff == nseu_pkg::ST_GRAD) begin
         g_ff  <= g_c[15:0];
         gr_ff <= gp[32:14] + 19'(gp[13]);
         lr_ff <= lpr[32:16];
         ll_ff <= label_ff ? llpos_q : llneg_q;
      end
      s1_idx_ff <= cnt_ff[3:0];
      s2_idx_ff <= s1_idx_ff;
      p1_ff     <= gr_ff * v_q;
      p2_ff     <= $signed({1'b0, lr_ff}) * u_q;
      p3_ff     <= gr_ff * u_q;
      p4_ff     <= $signed({1'b0, lr_ff}) * v_q;
      s2_v_ff   <= v_q;
      s2_e_ff   <= e_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit;
      end
      rsp_kind_ff     <= emit_kind;
      rsp_index_ff    <= emit_idx;
      rsp_value_ff    <= emit_val;
      rsp_run_last_ff <= emit_last;
      rsp_ll_ff       <= (emit_kind == nseu_pkg::KIND_SUM) ? ll_ff : 24'sd0;
      rsp_grad_ff     <= (emit_kind == nseu_pkg::KIND_SUM) ? g_ff : 16'sd0;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_log_lik   = rsp_ll_ff;
   assign rsp_bias_grad = rsp_grad_ff;
   assign rsp_run_last  = rsp_run_last_ff;

   a_rsp_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a run in progress");

   a_last_gap : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_last |=> !rsp_valid)
      else $error("result after the last beat of a run");

   a_s2_upd : assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> state_ff == nseu_pkg::ST_UPD)
      else $error("update stage active outside the target pass");

   a_pair_busy : assert property (@(posedge clock) disable iff (reset)
      accept && req_pair_last |=> busy)
      else $error("pair end did not start a run");

endmodule

`default_nettype wire
